// ===== rtl/core/tpha_pkg.sv =====
// shared types, widths and arctangent table for the three-plane heading angles pipeline
package tpha_pkg;

	localparam int unsigned IN_W   = 16;
	localparam int unsigned ANG_W  = 12;
	localparam int unsigned VEC_W  = 44;
	localparam int unsigned ZACC_W = 30;
	localparam int unsigned IN_SHIFT = 24;
	localparam int unsigned TAB_LEN = 32;

	// angles in 1/65536 tenth of a degree
	localparam logic signed [ZACC_W-1:0] HALF_TURN = ZACC_W'(117964800);

	localparam logic [ANG_W-1:0] ANG_0    = ANG_W'(0);
	localparam logic [ANG_W-1:0] ANG_450  = ANG_W'(450);
	localparam logic [ANG_W-1:0] ANG_900  = ANG_W'(900);
	localparam logic [ANG_W-1:0] ANG_1350 = ANG_W'(1350);
	localparam logic [ANG_W-1:0] ANG_1800 = ANG_W'(1800);
	localparam logic [ANG_W-1:0] ANG_2250 = ANG_W'(2250);
	localparam logic [ANG_W-1:0] ANG_2700 = ANG_W'(2700);
	localparam logic [ANG_W-1:0] ANG_3150 = ANG_W'(3150);
	localparam logic [ANG_W-1:0] ANG_3600 = ANG_W'(3600);

	typedef struct packed {
		logic signed [VEC_W-1:0]  x;
		logic signed [VEC_W-1:0]  y;
		logic signed [ZACC_W-1:0] z;
		logic                     exact;
		logic [ANG_W-1:0]         exact_ang;
	} vec_t;

	// atan(2^-i) in 1/65536 tenth of a degree, rounded to nearest
	function automatic logic signed [ZACC_W-1:0] atan_tab(input logic [4:0] i);
		logic signed [ZACC_W-1:0] r;
		case (i)
			5'd0:  r = ZACC_W'(29491200);
			5'd1:  r = ZACC_W'(17409672);
			5'd2:  r = ZACC_W'(9198793);
			5'd3:  r = ZACC_W'(4669451);
			5'd4:  r = ZACC_W'(2343787);
			5'd5:  r = ZACC_W'(1173036);
			5'd6:  r = ZACC_W'(586661);
			5'd7:  r = ZACC_W'(293348);
			5'd8:  r = ZACC_W'(146676);
			5'd9:  r = ZACC_W'(73338);
			5'd10: r = ZACC_W'(36669);
			5'd11: r = ZACC_W'(18335);
			5'd12: r = ZACC_W'(9167);
			5'd13: r = ZACC_W'(4584);
			5'd14: r = ZACC_W'(2292);
			5'd15: r = ZACC_W'(1146);
			5'd16: r = ZACC_W'(573);
			5'd17: r = ZACC_W'(286);
			5'd18: r = ZACC_W'(143);
			5'd19: r = ZACC_W'(72);
			5'd20: r = ZACC_W'(36);
			5'd21: r = ZACC_W'(18);
			5'd22: r = ZACC_W'(9);
			5'd23: r = ZACC_W'(4);
			5'd24: r = ZACC_W'(2);
			5'd25: r = ZACC_W'(1);
			5'd26: r = ZACC_W'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/tpha_stage.sv =====
// one registered cordic vectoring micro-rotation
module tpha_stage #(
	parameter int unsigned IDX = 0
) (
	input  logic           clk,
	input  logic           ce,
	input  tpha_pkg::vec_t d,
	output tpha_pkg::vec_t q
);

	tpha_pkg::vec_t nxt;
	logic signed [tpha_pkg::VEC_W-1:0] dx;
	logic signed [tpha_pkg::VEC_W-1:0] dy;
	logic signed [tpha_pkg::ZACC_W-1:0] ang;

	always_comb begin
		dx  = d.y >>> IDX;
		dy  = d.x >>> IDX;
		ang = tpha_pkg::atan_tab(5'(IDX));
		nxt = d;
		if (d.y > 0) begin
			nxt.x = d.x + dx;
			nxt.y = d.y - dy;
			nxt.z = d.z + ang;
		end else begin
			nxt.x = d.x - dx;
			nxt.y = d.y + dy;
			nxt.z = d.z - ang;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			q <= nxt;
		end
	end

endmodule

// ===== rtl/core/tpha_plane.sv =====
// angle pipeline for one plane: setup, micro-rotations, final scaling
module tpha_plane #(
	parameter int unsigned ITER = 20
) (
	input  logic                                clk,
	input  logic                                ce,
	input  logic signed [tpha_pkg::IN_W-1:0]    a,
	input  logic signed [tpha_pkg::IN_W-1:0]    b,
	output logic [tpha_pkg::ANG_W-1:0]          angle
);

	tpha_pkg::vec_t pipe [0:ITER];
	tpha_pkg::vec_t init;
	logic signed [tpha_pkg::VEC_W-1:0] ax;
	logic signed [tpha_pkg::VEC_W-1:0] by;
	logic signed [tpha_pkg::ZACC_W:0]  t;
	logic [tpha_pkg::ANG_W-1:0]        fin;

	always_comb begin
		ax = tpha_pkg::VEC_W'(a) <<< tpha_pkg::IN_SHIFT;
		by = tpha_pkg::VEC_W'(b) <<< tpha_pkg::IN_SHIFT;
		init = '0;
		init.x = ax;
		init.y = by;
		if (a < 0) begin
			init.x = -ax;
			init.y = -by;
			init.z = (b > 0) ? tpha_pkg::HALF_TURN : -tpha_pkg::HALF_TURN;
		end
		// axis and diagonal directions bypass the rotations
		init.exact = 1'b1;
		if (b == 0) begin
			init.exact_ang = (a < 0) ? tpha_pkg::ANG_3600 : tpha_pkg::ANG_1800;
		end else if (a == 0) begin
			init.exact_ang = (b > 0) ? tpha_pkg::ANG_2700 : tpha_pkg::ANG_900;
		end else if (a == b) begin
			init.exact_ang = (a > 0) ? tpha_pkg::ANG_2250 : tpha_pkg::ANG_450;
		end else if (a == -b) begin
			init.exact_ang = (a > 0) ? tpha_pkg::ANG_1350 : tpha_pkg::ANG_3150;
		end else begin
			init.exact = 1'b0;
			init.exact_ang = tpha_pkg::ANG_0;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			pipe[0] <= init;
		end
	end

	for (genvar i = 0; i < ITER; i++) begin : g_rot
		tpha_stage #(.IDX(i)) u_stage (
			.clk (clk),
			.ce  (ce),
			.d   (pipe[i]),
			.q   (pipe[i+1])
		);
	end

	always_comb begin
		t = {pipe[ITER].z[tpha_pkg::ZACC_W-1], pipe[ITER].z}
			+ {tpha_pkg::HALF_TURN[tpha_pkg::ZACC_W-1], tpha_pkg::HALF_TURN};
		if (pipe[ITER].exact) begin
			fin = pipe[ITER].exact_ang;
		end else if (t < 0) begin
			fin = tpha_pkg::ANG_0;
		end else if ((t >>> 16) > $signed({1'b0, tpha_pkg::ANG_3600})) begin
			fin = tpha_pkg::ANG_3600;
		end else begin
			fin = t[16 +: tpha_pkg::ANG_W];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			angle <= fin;
		end
	end

endmodule

// ===== rtl/core/three_plane_heading_angles_top.sv =====
// top level: stream wrapper around three plane angle pipelines
// Takes one sample (x, y, z) per cycle and returns atan2 for planes xy, xz and yz in tenths
// of a degree plus 180 (0..3600). The pipeline has one setup stage,
// one stage per cordic micro-rotation and one output register. Sustained rate is one
// transaction per cycle; the whole pipeline holds while the output is stalled.
module three_plane_heading_angles_top #(
	parameter int unsigned ANGLE_ITERATIONS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // x_axis[15:0], y_axis[31:16], z_axis[47:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // ang_xy[11:0], ang_xz[23:12], ang_yz[35:24], zero
);

	localparam int unsigned DEPTH = ANGLE_ITERATIONS + 2;

	logic ce;
	logic [DEPTH-1:0] vld_q;
	logic [tpha_pkg::ANG_W-1:0] ang_xy;
	logic [tpha_pkg::ANG_W-1:0] ang_xz;
	logic [tpha_pkg::ANG_W-1:0] ang_yz;
	logic signed [tpha_pkg::IN_W-1:0] x_axis;
	logic signed [tpha_pkg::IN_W-1:0] y_axis;
	logic signed [tpha_pkg::IN_W-1:0] z_axis;

	assign ce = !m_tvalid || m_tready;
	assign s_tready = ce;
	assign m_tvalid = vld_q[DEPTH-1];
	assign x_axis = s_tdata[15:0];
	assign y_axis = s_tdata[31:16];
	assign z_axis = s_tdata[47:32];
	assign m_tdata = {4'b0, ang_yz, ang_xz, ang_xy};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ce) begin
			vld_q <= {vld_q[DEPTH-2:0], s_tvalid};
		end
	end

	tpha_plane #(.ITER(ANGLE_ITERATIONS)) u_xy (
		.clk(clk), .ce(ce), .a(x_axis), .b(y_axis), .angle(ang_xy)
	);
	tpha_plane #(.ITER(ANGLE_ITERATIONS)) u_xz (
		.clk(clk), .ce(ce), .a(x_axis), .b(z_axis), .angle(ang_xz)
	);
	tpha_plane #(.ITER(ANGLE_ITERATIONS)) u_yz (
		.clk(clk), .ce(ce), .a(y_axis), .b(z_axis), .angle(ang_yz)
	);

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (ang_xy <= tpha_pkg::ANG_3600 && ang_xz <= tpha_pkg::ANG_3600
			&& ang_yz <= tpha_pkg::ANG_3600))
		else $error("angle out of range");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready not tied to output space");

	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(vld_q[DEPTH-2]))
		else $error("output valid without item in last stage");

endmodule
